@@ rtl/mbe_pkg.sv @@
// Package for the Mandelbrot escape-time block: shared constants, the
// control struct between sequencer and iteration unit, and width helpers.
// No dependencies.
package mbe_pkg;

   // iteration counter and limit register width
   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd1000;

   // defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 13;

   // width of z: holds |z^2| + |c| without overflow after an escape test
   function automatic int z_width(input int coord_w, input int frac_b);
      int base;
      base = (frac_b + 5 > coord_w) ? frac_b + 5 : coord_w;
      return base + 1;
   endfunction

   // request payload width, rounded up to whole bytes
   function automatic int req_data_width(input int coord_w);
      return ((2 * coord_w + 7) / 8) * 8;
   endfunction

   // sequencer commands to the iteration unit
   typedef struct packed {
      logic load;   // take a new c, clear z
      logic mul;    // register the three products of z
      logic upd;    // write z*z + c back into z
   } mbe_ctrl_type;

endpackage

@@ rtl/mbe_iter_unit.sv @@
// Shared iteration unit: holds z and c, registers re^2, im^2 and re*im,
// then forms the escape test and z*z + c from those products. Uses mbe_pkg.
module mbe_iter_unit import mbe_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  mbe_ctrl_type                  ctrl,
   input  logic signed [COORD_WIDTH-1:0] c_re,
   input  logic signed [COORD_WIDTH-1:0] c_im,
   output logic                          escaped
);

   localparam int ZW = z_width(COORD_WIDTH, FRAC_BITS);
   // operand width: a component no larger than 2.0 in magnitude
   localparam int MW = FRAC_BITS + 3;
   localparam int PW = 2 * MW;
   localparam logic signed [ZW-1:0] TWO     = ZW'(2) <<< FRAC_BITS;
   localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
   localparam logic [PW:0]          FOUR_SQ = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

   logic signed [ZW-1:0]          z_re_ff, z_re_in;
   logic signed [ZW-1:0]          z_im_ff, z_im_in;
   logic signed [COORD_WIDTH-1:0] c_re_ff, c_im_ff;
   logic signed [PW-1:0]          sq_re_ff, sq_im_ff, cross_ff;
   logic                          big_ff;

   logic signed [MW-1:0] op_re, op_im;
   logic                 big_in;
   logic signed [PW-1:0] diff, cross2;
   logic [PW:0]          mag_sq;

   // narrow operands are exact whenever neither component exceeds 2.0
   assign op_re  = z_re_ff[MW-1:0];
   assign op_im  = z_im_ff[MW-1:0];
   assign big_in = (z_re_ff > TWO) || (z_re_ff < NEG_TWO) ||
                   (z_im_ff > TWO) || (z_im_ff < NEG_TWO);

   // escape test on the registered products
   assign mag_sq  = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign escaped = big_ff || (mag_sq > FOUR_SQ);

   // z*z + c, products scaled back by a flooring shift
   assign diff   = sq_re_ff - sq_im_ff;
   assign cross2 = cross_ff <<< 1;

   always_comb begin
      z_re_in = z_re_ff;
      z_im_in = z_im_ff;
      if (ctrl.load) begin
         z_re_in = '0;
         z_im_in = '0;
      end else if (ctrl.upd) begin
         z_re_in = ZW'($signed(diff[PW-1:FRAC_BITS])) + ZW'(c_re_ff);
         z_im_in = ZW'($signed(cross2[PW-1:FRAC_BITS])) + ZW'(c_im_ff);
      end
   end

   // hold z and c, capture the products
   always_ff @(posedge clock) begin
      z_re_ff <= z_re_in;
      z_im_ff <= z_im_in;
      if (ctrl.load) begin
         c_re_ff <= c_re;
         c_im_ff <= c_im;
      end
      if (ctrl.mul) begin
         sq_re_ff <= op_re * op_re;
         sq_im_ff <= op_im * op_im;
         cross_ff <= op_re * op_im;
         big_ff   <= big_in;
      end
   end

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time counter for one point c per request.
// Uses mbe_pkg and mbe_iter_unit.
//
// Channels: req_* carries one point c (Q format with FRAC_BITS fraction
// bits) per transfer; rsp_* returns its escape count, one transfer per
// request. csr_wr_en writes max_iterations (reset value 1000); the user is to
// assert it only while the block is idle, as the block does not enforce this.
// Sequence: each iteration uses the shared unit for a multiply step, then
// an escape test and update step. A limit of zero skips the iteration
// and posts a count of zero.
// Throughput: one point at a time; req_tready is high only while the
// sequencer is idle and comes back at the edge that posts the count. A
// finished count sits in the output register, so the next point may be
// taken while the receiver stalls; a second count then waits inside until
// rsp_tready frees it.
// Reset: synchronous, active high; clears the sequencer and the output
// valid and restores max_iterations to 1000.
module mandelbrot_escape_time import mbe_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // configuration
   input  logic                                      csr_wr_en,
   input  logic [CNT_W-1:0]                          csr_wr_data,  // max_iterations
   // request stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [req_data_width(COORD_WIDTH)-1:0]    req_tdata,    // c_re, c_im, zero pad
   // response stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [CNT_W-1:0]                          rsp_tdata     // iteration_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] max_iter_ff, max_iter_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_data_ff, rsp_data_in;

   mbe_ctrl_type ctrl;
   logic         escaped;
   logic         req_xfer;
   logic [CNT_W-1:0] count_inc;

   logic signed [COORD_WIDTH-1:0] c_re, c_im;

   assign c_re = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign c_im = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign count_inc  = count_ff + 1'b1;

   mbe_iter_unit #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_iter (
      .clock   (clock),
      .ctrl    (ctrl),
      .c_re    (c_re),
      .c_im    (c_im),
      .escaped (escaped)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      max_iter_in  = csr_wr_en ? csr_wr_data : max_iter_ff;
      lim_in       = lim_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ctrl.load = 1'b1;
               lim_in    = max_iter_ff;
               count_in  = '0;
               state_in  = (max_iter_ff == '0) ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (escaped) begin
               state_in = ST_FIN;
            end else begin
               ctrl.upd = 1'b1;
               count_in = count_inc;
               state_in = (count_inc == lim_ff) ? ST_FIN : ST_MUL;
            end
         end
         ST_FIN: begin
            // post once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_iter_ff  <= max_iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff      <= lim_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the count never reaches the latched limit while still iterating
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (count_ff < lim_ff))
      else $error("iteration count reached limit while iterating");

   // an update always follows a multiply cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $past(state_ff == ST_MUL))
      else $error("update without preceding multiply");

   // a new response appears only out of the finish state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response posted outside finish state");

endmodule

@@ dv/mandelbrot_escape_time_tb.sv @@
// Self-checking testbench for mandelbrot_escape_time: drives points c over the
// request stream, predicts each escape count and checks every response.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
   import mbe_pkg::*;

   localparam int COORD_W = COORD_WIDTH_DEF;
   localparam int FRAC_B = FRAC_BITS_DEF;
   localparam int REQ_W = req_data_width(COORD_W);

   // escape thresholds: |component| > 2 and re^2 + im^2 > 4
   localparam longint TWO_FIX = longint'(2) << FRAC_B;
   localparam longint FOUR_SQ_FIX = longint'(4) << (2 * FRAC_B);

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_BATCHES = 10;
   localparam int BATCH_POINTS = 60;
   localparam longint TIMEOUT_NS = 40_000_000;

   typedef struct {
      logic signed [COORD_W-1:0] re;
      logic signed [COORD_W-1:0] im;
   } point_type;

   typedef struct {
      point_type c;
      logic [CNT_W-1:0] count;
   } expected_count_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // c_re, c_im, zero pad
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [CNT_W-1:0] rsp_tdata;        // iteration_count

   point_type pending_points[$];
   expected_count_type expected_counts[$];
   logic [CNT_W-1:0] iter_limit = MAX_ITER_RESET;
   bit idle_enable = 1'b1;
   bit rsp_hold_req = 1'b0;
   bit req_accepted = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned mismatches = 0;

   mandelbrot_escape_time #(
      .COORD_WIDTH(COORD_W),
      .FRAC_BITS(FRAC_B)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Iterate z = z*z + c from zero, testing for escape before each step.
   function automatic logic [CNT_W-1:0] escape_count(input point_type c,
                                                     input logic [CNT_W-1:0] limit);
      longint zr, zi, nr, ni, ar, ai;
      int unsigned n;
      zr = 0;
      zi = 0;
      n = 0;
      while (n < limit) begin
         ar = (zr < 0) ? -zr : zr;
         ai = (zi < 0) ? -zi : zi;
         if (ar > TWO_FIX || ai > TWO_FIX || ar * ar + ai * ai > FOUR_SQ_FIX)
            break;
         // arithmetic shift floors toward minus infinity
         nr = ((zr * zr - zi * zi) >>> FRAC_B) + longint'(c.re);
         ni = ((2 * zr * zi) >>> FRAC_B) + longint'(c.im);
         zr = nr;
         zi = ni;
         n++;
      end
      return n[CNT_W-1:0];
   endfunction

   // Mostly points around the set, the rest anywhere in the coordinate range.
   function automatic point_type random_point();
      point_type p;
      if ($urandom_range(0, 3) == 0) begin
         p.re = COORD_W'($urandom);
         p.im = COORD_W'($urandom);
      end else begin
         p.re = COORD_W'($urandom_range(0, 20480) - 16384);
         p.im = COORD_W'($urandom_range(0, 20480) - 10240);
      end
      return p;
   endfunction

   task automatic push_point(input int re, input int im);
      point_type p;
      p.re = re[COORD_W-1:0];
      p.im = im[COORD_W-1:0];
      pending_points.push_back(p);
   endtask

   // Step just past the rising edge so all edge updates have settled.
   task automatic sync_tick();
      @(posedge clock);
      #1;
   endtask

   task automatic wait_drained();
      do
         sync_tick();
      while (pending_points.size() != 0 || req_tvalid || expected_counts.size() != 0);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      iter_limit = value;
      sync_tick();
   endtask

   // Request driver: hold a point until its transfer, then pick a gap or the next one.
   always @(negedge clock) begin : req_driver
      point_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (req_gap_left > 0) begin
            req_tvalid <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            req_gap_left <= $urandom_range(0, 5);
         end else if (pending_points.size() != 0) begin
            p = pending_points.pop_front();
            req_tdata <= {{(REQ_W - 2 * COORD_W){1'b0}}, p.im, p.re};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: long hold-off on request, random stall bursts otherwise.
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_hold_req) begin
         rsp_hold_req = 1'b0;
         rsp_tready <= 1'b0;
         rsp_stall_left <= LONG_HOLD_CYCLES;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on each request transfer, check each response transfer.
   always @(posedge clock) begin : monitor
      expected_count_type e;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            e.c.re = req_tdata[COORD_W-1:0];
            e.c.im = req_tdata[2*COORD_W-1:COORD_W];
            e.count = escape_count(e.c, iter_limit);
            expected_counts.push_back(e);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected count transfer: expected none, actual %0d",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               e = expected_counts.pop_front();
               if (rsp_tdata !== e.count) begin
                  $display("%0t: count mismatch for c=(%0d,%0d): expected %0d, actual %0d",
                           $time, e.c.re, e.c.im, e.count, rsp_tdata);
                  mismatches++;
               end
            end
         end
      end
   end

   // Sequencer: reset, directed points, limit extremes, pressure, random batches.
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      sync_tick();

      // reset limit of 1000: origin, corners, exact escape radius, rounding signs
      push_point(0, 0);
      push_point(32767, 32767);
      push_point(-32768, -32768);
      push_point(-32768, 32767);
      push_point(32767, -32768);
      push_point(-16384, 0);
      push_point(16384, 0);
      push_point(0, 16384);
      push_point(16385, 0);
      push_point(-16385, 0);
      push_point(-8192, 0);
      push_point(0, 8192);
      push_point(2048, 0);
      push_point(2049, 0);
      push_point(-1, -1);
      push_point(1, 1);
      push_point(-1, 0);
      push_point(0, -1);
      push_point(-14745, 0);
      push_point(11585, 11585);
      push_point(-6144, 5325);
      wait_drained();

      // zero limit answers zero, limit of one always counts one
      write_limit('0);
      for (int k = 0; k < 6; k++)
         pending_points.push_back(random_point());
      wait_drained();
      write_limit(CNT_W'(1));
      for (int k = 0; k < 6; k++)
         pending_points.push_back(random_point());
      wait_drained();

      // full-scale limit: one point never escapes
      write_limit('1);
      push_point(0, 0);
      push_point(16384, 0);
      push_point(-32768, 32767);
      wait_drained();

      // receiver holds off long enough that the block fills and stalls requests
      write_limit(CNT_W'(8));
      rsp_hold_req = 1'b1;
      for (int k = 0; k < 12; k++)
         pending_points.push_back(random_point());
      wait_drained();

      // random batches with small limits; no idling in the last one
      for (int b = 0; b < RANDOM_BATCHES; b++) begin
         if (b == RANDOM_BATCHES - 1)
            idle_enable = 1'b0;
         write_limit(CNT_W'($urandom_range(2, 64)));
         for (int k = 0; k < BATCH_POINTS; k++)
            pending_points.push_back(random_point());
         wait_drained();
      end

      // let any stray response show up before the verdict
      repeat (2 * iter_limit + 8) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
